### sv/kcg_pkg.sv
// ----------------------------------------------------------------------------
// kcg_pkg
// Shared types and constants of the key change event generator.
// ----------------------------------------------------------------------------
package kcg_pkg;

  // widest key index the block supports (32 keys)
  localparam int KEY_IDX_W = 5;
  localparam int KEY_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_SET  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_KEY = 1'b1;

  // event request from the scanner to the output buffer
  typedef struct packed {
    logic                 valid;
    logic                 fin;
    logic [KEY_IDX_W-1:0] idx;
    logic                 press;
  } kcg_ev_t;

endpackage

### sv/kcg_in_if.sv
// ----------------------------------------------------------------------------
// kcg_in_if
// Input channel: one key bitmap per item.
// ----------------------------------------------------------------------------
interface kcg_in_if;

  logic        valid;
  logic        ready;
  logic [31:0] pressed_keys;

  modport source (output valid, output pressed_keys, input ready);
  modport sink   (input valid, input pressed_keys, output ready);

endinterface

### sv/kcg_out_if.sv
// ----------------------------------------------------------------------------
// kcg_out_if
// Result channel: one key event per item.
// ----------------------------------------------------------------------------
interface kcg_out_if;

  logic       valid;
  logic       ready;
  logic [7:0] event_set;
  logic [7:0] event_key;
  logic       event_press;
  logic       last_event;

  modport source (output valid, output event_set, output event_key,
                  output event_press, output last_event, input ready);
  modport sink   (input valid, input event_set, input event_key,
                  input event_press, input last_event, output ready);

endinterface

### sv/key_change_event_generator.sv
// ----------------------------------------------------------------------------
// key_change_event_generator
// Turns key bitmaps into release and press events.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries one key bitmap per item (valid/ready). Releases (bits that
//   dropped) come out first in ascending key order, then presses (bits that
//   rose) in descending order; each event carries key_set and
//   base_key + bit index mod 256, and the final event of a bitmap has
//   last_event set. An unchanged bitmap gives no events.
//   cfg_we/cfg_index/cfg_data write key_set (index 0) and base_key (index 1)
//   while the block is idle.
//   The block takes a new bitmap only while the scanner is idle; the
//   scanner turns both bitmaps once up and once down, one bit a cycle while
//   the receiver does not stall. An event is held until the next changed
//   bit or the scan end shows whether it is last. A stalled receiver freezes
//   the scanner at the next changed bit; one event waits in a hold register
//   and one in the output register.
//   Reset clears the stored bitmap (all keys released) and both registers.
// ----------------------------------------------------------------------------
module key_change_event_generator #(
  parameter int KEY_COUNT = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [kcg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kcg_pkg::CFG_W-1:0]         cfg_data,
  kcg_in_if.sink                            in_if,
  kcg_out_if.source                         out_if
);

  logic [kcg_pkg::KEY_W-1:0] key_set_r;
  logic [kcg_pkg::KEY_W-1:0] base_key_r;
  logic                      scan_idle;
  logic                      start;
  kcg_pkg::kcg_ev_t          ev;
  logic                      ev_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_set_r  <= '0;
      base_key_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kcg_pkg::CFG_KEY_SET:  key_set_r  <= cfg_data;
        kcg_pkg::CFG_BASE_KEY: base_key_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_if.ready = scan_idle;
  assign start       = in_if.valid && scan_idle;

  kcg_scan #(
    .KEY_COUNT (KEY_COUNT)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .keys_in  (in_if.pressed_keys[KEY_COUNT-1:0]),
    .idle     (scan_idle),
    .ev       (ev),
    .ev_ready (ev_ready)
  );

  kcg_outbuf u_outbuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev       (ev),
    .ev_ready (ev_ready),
    .key_set  (key_set_r),
    .base_key (base_key_r),
    .out_if   (out_if)
  );

endmodule

### sv/kcg_scan.sv
// ----------------------------------------------------------------------------
// kcg_scan
// Bit-serial change scanner: rotates stored and new bitmaps one bit a cycle
// unless an event stalls, ascending for releases, then descending for presses.
// ----------------------------------------------------------------------------
module kcg_scan #(
  parameter int KEY_COUNT = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [KEY_COUNT-1:0] keys_in,
  output logic                 idle,
  output kcg_pkg::kcg_ev_t     ev,
  input  logic                 ev_ready
);

  localparam int IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(KEY_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_REL  = 4'b0010,
    S_PRS  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [KEY_COUNT-1:0] known_r, known_nxt;
  logic [KEY_COUNT-1:0] now_r, now_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic                 diff;
  logic                 advance;

  assign idle = (state_r == S_IDLE);

  always_comb begin
    diff = 1'b0;
    unique case (state_r)
      S_REL:   diff = known_r[0] & ~now_r[0];
      S_PRS:   diff = now_r[KEY_COUNT-1] & ~known_r[KEY_COUNT-1];
      default: diff = 1'b0;
    endcase
  end

  always_comb begin
    ev.valid = diff || (state_r == S_FIN);
    ev.fin   = (state_r == S_FIN);
    ev.idx   = kcg_pkg::KEY_IDX_W'(idx_r);
    ev.press = (state_r == S_PRS);
  end

  assign advance = !diff || ev_ready;

  always_comb begin
    state_nxt = state_r;
    known_nxt = known_r;
    now_nxt   = now_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          now_nxt   = keys_in;
          idx_nxt   = '0;
          state_nxt = S_REL;
        end
      end
      S_REL: begin
        if (advance) begin
          known_nxt = (known_r >> 1) | (known_r << (KEY_COUNT - 1));
          now_nxt   = (now_r >> 1) | (now_r << (KEY_COUNT - 1));
          // both maps are back in place after a full turn
          if (idx_r == IDX_TOP) begin
            state_nxt = S_PRS;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      S_PRS: begin
        if (advance) begin
          known_nxt = (known_r << 1) | (known_r >> (KEY_COUNT - 1));
          now_nxt   = (now_r << 1) | (now_r >> (KEY_COUNT - 1));
          if (idx_r == '0) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      S_FIN: begin
        if (ev_ready) begin
          known_nxt = now_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      known_r <= '0;
    end else begin
      state_r <= state_nxt;
      known_r <= known_nxt;
    end
  end

  always_ff @(posedge clk) begin
    now_r <= now_nxt;
    idx_r <= idx_nxt;
  end

  a_start_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && start) |=> (state_r == S_REL && idx_r == '0))
    else $error("scan did not start at bit zero");

  a_rel_to_prs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_REL && state_nxt == S_PRS) |=> (idx_r == IDX_TOP))
    else $error("press pass did not start at top bit");

  a_fin_stores: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && ev_ready) |=> (state_r == S_IDLE && known_r == $past(now_r)))
    else $error("stored bitmap not updated at end of scan");

endmodule

### sv/kcg_outbuf.sv
// ----------------------------------------------------------------------------
// kcg_outbuf
// Holds one event back so the final event of a bitmap can be marked, and
// drives the result channel from an output register.
// ----------------------------------------------------------------------------
module kcg_outbuf (
  input  logic                           clk,
  input  logic                           rst_n,
  input  kcg_pkg::kcg_ev_t               ev,
  output logic                           ev_ready,
  input  logic [kcg_pkg::KEY_W-1:0]      key_set,
  input  logic [kcg_pkg::KEY_W-1:0]      base_key,
  kcg_out_if.source                      out_if
);

  logic                            pend_v_r, pend_v_nxt;
  logic [kcg_pkg::KEY_IDX_W-1:0]   pend_idx_r, pend_idx_nxt;
  logic                            pend_press_r, pend_press_nxt;
  logic                            out_v_r, out_v_nxt;
  logic [kcg_pkg::KEY_W-1:0]       out_set_r, out_set_nxt;
  logic [kcg_pkg::KEY_W-1:0]       out_key_r, out_key_nxt;
  logic                            out_press_r, out_press_nxt;
  logic                            out_last_r, out_last_nxt;
  logic                            ev_hs;

  assign ev_ready = !pend_v_r || !out_v_r || out_if.ready;
  assign ev_hs    = ev.valid && ev_ready;

  always_comb begin
    pend_v_nxt     = pend_v_r;
    pend_idx_nxt   = pend_idx_r;
    pend_press_nxt = pend_press_r;
    out_v_nxt      = out_v_r && !out_if.ready;
    out_set_nxt    = out_set_r;
    out_key_nxt    = out_key_r;
    out_press_nxt  = out_press_r;
    out_last_nxt   = out_last_r;
    if (ev_hs) begin
      // the held event goes out once we know whether another follows
      if (pend_v_r) begin
        out_v_nxt     = 1'b1;
        out_set_nxt   = key_set;
        out_key_nxt   = base_key + kcg_pkg::KEY_W'(pend_idx_r);
        out_press_nxt = pend_press_r;
        out_last_nxt  = ev.fin;
      end
      pend_v_nxt     = !ev.fin;
      pend_idx_nxt   = ev.idx;
      pend_press_nxt = ev.press;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r   <= pend_idx_nxt;
    pend_press_r <= pend_press_nxt;
    out_set_r    <= out_set_nxt;
    out_key_r    <= out_key_nxt;
    out_press_r  <= out_press_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_if.valid       = out_v_r;
  assign out_if.event_set   = out_set_r;
  assign out_if.event_key   = out_key_r;
  assign out_if.event_press = out_press_r;
  assign out_if.last_event  = out_last_r;

  a_fin_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_hs && ev.fin) |=> !pend_v_r)
    else $error("held event survived end of scan");

  a_ev_held: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_hs && !ev.fin) |=> pend_v_r)
    else $error("event not held");

  a_mid_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_hs && !ev.fin && pend_v_r) |=> (out_v_r && !out_last_r))
    else $error("event marked last while more follow");

endmodule
